@@ sv/voxel_ray_march_assert.svh @@
// assertion macros used by the voxel ray marcher controller
`ifndef VOXEL_RAY_MARCH_ASSERT_SVH
`define VOXEL_RAY_MARCH_ASSERT_SVH

// same-cycle implication
`define VRM_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define VRM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/vrm_pkg.sv @@
// types, constants and register map of the voxel ray marcher
`timescale 1ns / 1ps
package vrm_pkg;

    localparam int GRID_X_DEF    = 32;
    localparam int GRID_Y_DEF    = 32;
    localparam int GRID_Z_DEF    = 16;
    localparam int MAX_STEPS_DEF = 512;

    localparam int PW       = 20;
    localparam int NUM_W    = 25;
    localparam int DEN_W    = 17;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [7:0] RESET_CODE = 8'd32;

    localparam logic [9:0]  EPS_RST    = 10'd10;
    localparam logic [8:0]  BORDER_RST = 9'd51;
    localparam logic [15:0] CAP_RST    = 16'd2048;
    localparam logic [7:0]  EMPTY_RST  = 8'd32;
    localparam logic [7:0]  EDGE_RST   = 8'd45;

    localparam logic [CFG_IW-1:0] REG_STEP_EPS   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_BORDER     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_STEP_CAP   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_EMPTY_CODE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_EDGE_CODE  = 3'd4;

    typedef enum logic [1:0] {
        KIND_ESCAPE,
        KIND_FACE,
        KIND_EDGE,
        KIND_LIMIT
    } t_kind;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       wr;
        logic       rd;
        logic       t_init;
        logic       div_start;
        logic       t_upd;
        logic       s_calc;
        logic       mul;
        logic       add;
        logic       step_inc;
        logic       res_set;
        t_kind      res_kind;
        logic       fin;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic       outside;
        logic       hit;
        logic       edge_hit;
        logic       clr_last;
        logic [2:0] used;
        logic       div_done;
        logic       last_step;
    } t_sts;

endpackage

@@ sv/voxel_ray_march.sv @@
// top level of the voxel ray marcher
//
// channel   dir  handshake                  payload
// s_axis    in   tvalid / tready            tuser action, tdata cell and ray fields
// m_axis    out  tvalid / tready            tuser hit_kind, tdata hit_code
// cfg       in   wr_en                      index, data
//
// after reset the store is swept to the empty code, one entry a cycle, over all
// GRID_X*GRID_Y*GRID_Z entries (16384 by default) before the first input transfer
// a march step of a cast checks the position, reads the cell, runs the serial
// divider on each direction axis outside the dead zone and then moves each axis
// a finished result sits in the output register while the next input is taken
`timescale 1ns / 1ps
module voxel_ray_march #(
    parameter int GRID_X    = vrm_pkg::GRID_X_DEF,
    parameter int GRID_Y    = vrm_pkg::GRID_Y_DEF,
    parameter int GRID_Z    = vrm_pkg::GRID_Z_DEF,
    parameter int MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // cell_x, cell_y, cell_z, cell_code, origin_x/y/z, dir_x/y/z, zero pad
    input  logic [127:0]               i_s_axis_tdata,
    // action
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // hit_code
    output logic [7:0]                 o_m_axis_tdata,
    // hit_kind
    output logic [1:0]                 o_m_axis_tuser,
    input  logic                       i_cfg_wr_en,
    input  logic [vrm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vrm_pkg::CFG_DW-1:0] i_cfg_data
);
    import vrm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vrm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(i_s_axis_tvalid),
        .i_action (i_s_axis_tuser),
        .o_s_ready(o_s_axis_tready),
        .i_m_ready(i_m_axis_tready),
        .o_m_valid(o_m_axis_tvalid),
        .o_kind   (o_m_axis_tuser),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    vrm_datapath #(
        .GRID_X   (GRID_X),
        .GRID_Y   (GRID_Y),
        .GRID_Z   (GRID_Z),
        .MAX_STEPS(MAX_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cell_x   (i_s_axis_tdata[4:0]),
        .i_cell_y   (i_s_axis_tdata[9:5]),
        .i_cell_z   (i_s_axis_tdata[13:10]),
        .i_cell_code(i_s_axis_tdata[21:14]),
        .i_origin_x ($signed(i_s_axis_tdata[38:22])),
        .i_origin_y ($signed(i_s_axis_tdata[55:39])),
        .i_origin_z ($signed(i_s_axis_tdata[72:56])),
        .i_dir_x    ($signed(i_s_axis_tdata[88:73])),
        .i_dir_y    ($signed(i_s_axis_tdata[104:89])),
        .i_dir_z    ($signed(i_s_axis_tdata[120:105])),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_code     (o_m_axis_tdata)
    );
endmodule

@@ sv/vrm_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vrm_divider #(
    parameter int NW = vrm_pkg::NUM_W,
    parameter int DW = vrm_pkg::DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   shifted;
    logic          ge;

    assign shifted = {r_rem, r_quo[NW-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(shifted - {1'b0, r_den}) : DW'(shifted);
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ sv/vrm_datapath.sv @@
// datapath: voxel store, config registers, position, step distance and move
`timescale 1ns / 1ps
module vrm_datapath #(
    parameter int GRID_X    = vrm_pkg::GRID_X_DEF,
    parameter int GRID_Y    = vrm_pkg::GRID_Y_DEF,
    parameter int GRID_Z    = vrm_pkg::GRID_Z_DEF,
    parameter int MAX_STEPS = vrm_pkg::MAX_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [vrm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vrm_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic [4:0]                 i_cell_x,
    input  logic [4:0]                 i_cell_y,
    input  logic [3:0]                 i_cell_z,
    input  logic [7:0]                 i_cell_code,
    input  logic signed [16:0]         i_origin_x,
    input  logic signed [16:0]         i_origin_y,
    input  logic signed [16:0]         i_origin_z,
    input  logic signed [15:0]         i_dir_x,
    input  logic signed [15:0]         i_dir_y,
    input  logic signed [15:0]         i_dir_z,
    input  vrm_pkg::t_cmd              i_cmd,
    output vrm_pkg::t_sts              o_sts,
    output logic [7:0]                 o_code
);
    import vrm_pkg::*;

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_STEPS);
    localparam logic signed [PW-1:0] LIM_X = PW'(GRID_X * 1024);
    localparam logic signed [PW-1:0] LIM_Y = PW'(GRID_Y * 1024);
    localparam logic signed [PW-1:0] LIM_Z = PW'(GRID_Z * 1024);

    logic [9:0]  r_eps;
    logic [8:0]  r_border;
    logic [15:0] r_cap;
    logic [7:0]  r_empty;
    logic [7:0]  r_edge;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_clr;

    logic signed [PW-1:0] r_p   [3];
    logic signed [15:0]   r_dir [3];
    logic [SW-1:0]        r_steps;
    logic [15:0]          r_t;
    logic [16:0]          r_s;
    logic signed [33:0]   r_prod;
    logic [7:0]           r_res_code;
    logic [7:0]           r_ocode;

    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              wr_in_grid;
    logic [2:0]        near;
    logic [2:0]        used;
    logic [13:0]       dead;
    logic [9:0]        f_sel;
    logic signed [15:0] dir_sel;
    logic [10:0]       num;
    logic [16:0]       d17;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  quo;
    logic              div_done;
    logic [33:0]       mag;
    logic [33:0]       rnd;
    logic signed [PW-1:0] move;
    logic signed [PW-1:0] delta;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= EPS_RST;
            r_border <= BORDER_RST;
            r_cap    <= CAP_RST;
            r_empty  <= EMPTY_RST;
            r_edge   <= EDGE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_STEP_EPS:   r_eps    <= i_cfg_data[9:0];
                REG_BORDER:     r_border <= i_cfg_data[8:0];
                REG_STEP_CAP:   r_cap    <= i_cfg_data;
                REG_EMPTY_CODE: r_empty  <= i_cfg_data[7:0];
                REG_EDGE_CODE:  r_edge   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // voxel store
    assign wr_in_grid = (int'(i_cell_x) < GRID_X) && (int'(i_cell_y) < GRID_Y)
                        && (int'(i_cell_z) < GRID_Z);
    assign wr_addr = AW'((int'(i_cell_z) * GRID_Y + int'(i_cell_y)) * GRID_X
                         + int'(i_cell_x));
    assign rd_addr = AW'((int'(r_p[2][PW-1:10]) * GRID_Y + int'(r_p[1][PW-1:10]))
                         * GRID_X + int'(r_p[0][PW-1:10]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr] <= RESET_CODE;
        end else if (i_cmd.wr && wr_in_grid) begin
            r_mem[wr_addr] <= i_cell_code;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // per-axis tests
    assign dead = {r_eps, 4'b0000};

    always_comb begin
        logic [10:0] fa;
        logic [10:0] ga;
        logic [10:0] edge_dist;
        logic signed [17:0] d18;
        logic signed [17:0] dd;
        near = '0;
        used = '0;
        for (int a = 0; a < 3; a++) begin
            fa        = {1'b0, r_p[a][9:0]};
            ga        = 11'd1024 - fa;
            edge_dist = (fa < ga) ? fa : ga;
            near[a]   = edge_dist < {2'b00, r_border};
            d18       = 18'(r_dir[a]);
            dd        = $signed({4'b0000, dead});
            used[a]   = (d18 > dd) || (d18 < -dd);
        end
    end

    // boundary distance along the selected axis
    assign f_sel   = r_p[i_cmd.axis][9:0];
    assign dir_sel = r_dir[i_cmd.axis];
    assign num     = dir_sel[15] ? {1'b0, f_sel} : (11'd1024 - {1'b0, f_sel});
    assign d17     = {dir_sel[15], dir_sel};
    assign den     = d17[16] ? (17'd0 - d17) : d17;

    vrm_divider #(
        .NW(NUM_W),
        .DW(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  ({num, 14'd0}),
        .i_den  (den),
        .o_done (div_done),
        .o_quo  (quo)
    );

    // rounded move, ties away from zero
    assign mag   = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
    assign rnd   = (mag + 34'd8192) >> 14;
    assign move  = PW'(rnd);
    assign delta = r_prod[33] ? -move : move;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p[0]   <= PW'(i_origin_x);
            r_p[1]   <= PW'(i_origin_y);
            r_p[2]   <= PW'(i_origin_z);
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
        end else if (i_cmd.add) begin
            r_p[i_cmd.axis] <= r_p[i_cmd.axis] + delta;
        end
        if (i_cmd.t_init) begin
            r_t <= r_cap;
        end else if (i_cmd.t_upd && (quo < {9'd0, r_t})) begin
            r_t <= quo[15:0];
        end
        if (i_cmd.s_calc) begin
            r_s <= {1'b0, r_t} + {7'd0, r_eps};
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_s}) * dir_sel;
        end
        if (i_cmd.res_set) begin
            case (i_cmd.res_kind)
                KIND_FACE: r_res_code <= r_rd_data;
                KIND_EDGE: r_res_code <= r_edge;
                default:   r_res_code <= r_empty;
            endcase
        end
        if (i_cmd.fin) begin
            r_ocode <= r_res_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_cmd.load) begin
            r_steps <= '0;
        end else if (i_cmd.step_inc) begin
            r_steps <= r_steps + 1'b1;
        end
    end

    assign o_sts.outside = (r_p[0] < 0) || (r_p[0] >= LIM_X)
                           || (r_p[1] < 0) || (r_p[1] >= LIM_Y)
                           || (r_p[2] < 0) || (r_p[2] >= LIM_Z);
    assign o_sts.hit       = r_rd_data != r_empty;
    assign o_sts.edge_hit  = (near[0] & near[1]) | (near[0] & near[2]) | (near[1] & near[2]);
    assign o_sts.clr_last  = r_clr == AW'(DEPTH - 1);
    assign o_sts.used      = used;
    assign o_sts.div_done  = div_done;
    assign o_sts.last_step = r_steps == SW'(MAX_STEPS - 1);
    assign o_code          = r_ocode;
endmodule

@@ sv/vrm_ctrl.sv @@
// controller: clear sweep, cast sequencing and result handshake
`timescale 1ns / 1ps
`include "voxel_ray_march_assert.svh"
module vrm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_action,
    output logic           o_s_ready,
    input  logic           i_m_ready,
    output logic           o_m_valid,
    output logic [1:0]     o_kind,
    output vrm_pkg::t_cmd  o_cmd,
    input  vrm_pkg::t_sts  i_sts
);
    import vrm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LOOK,
        S_DIV,
        S_DIVW,
        S_SUM,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_axis;
    t_kind      r_kind;
    t_kind      r_okind;
    logic       r_ovalid;
    logic       accept;
    logic       out_free;

    assign o_s_ready = r_state == S_IDLE;
    assign accept    = i_s_valid && o_s_ready;
    assign out_free  = !r_ovalid || i_m_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.axis     = r_axis;
        o_cmd.res_kind = KIND_ESCAPE;
        unique case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_cmd.load = accept;
                o_cmd.wr   = accept && !i_action;
            end
            S_CHECK: begin
                if (i_sts.outside) begin
                    o_cmd.res_set = 1'b1;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_LOOK: begin
                if (i_sts.hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = i_sts.edge_hit ? KIND_EDGE : KIND_FACE;
                end else begin
                    o_cmd.t_init = 1'b1;
                end
            end
            S_DIV:  o_cmd.div_start = i_sts.used[r_axis];
            S_DIVW: o_cmd.t_upd = i_sts.div_done;
            S_SUM:  o_cmd.s_calc = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_axis == 2'd2) begin
                    o_cmd.step_inc = 1'b1;
                    o_cmd.res_set  = i_sts.last_step;
                    o_cmd.res_kind = KIND_LIMIT;
                end
            end
            S_DONE: o_cmd.fin = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_axis   <= '0;
            r_kind   <= KIND_ESCAPE;
            r_okind  <= KIND_ESCAPE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_action) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.outside) begin
                        r_kind  <= KIND_ESCAPE;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (i_sts.hit) begin
                        r_kind  <= i_sts.edge_hit ? KIND_EDGE : KIND_FACE;
                        r_state <= S_DONE;
                    end else begin
                        r_axis  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_sts.used[r_axis]) begin
                        r_state <= S_DIVW;
                    end else if (r_axis == 2'd2) begin
                        r_state <= S_SUM;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_DIVW: begin
                    if (i_sts.div_done) begin
                        if (r_axis == 2'd2) begin
                            r_state <= S_SUM;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_SUM: begin
                    r_axis  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ADD;
                S_ADD: begin
                    if (r_axis == 2'd2) begin
                        r_axis <= '0;
                        if (i_sts.last_step) begin
                            r_kind  <= KIND_LIMIT;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end else begin
                        r_axis  <= r_axis + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_kind    = r_okind;

    `VRM_ASSERT_IMPL(a_axis_range, i_clk, i_rst_n, 1'b1, r_axis != 2'd3, "axis index out of range")
    `VRM_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, r_state != S_CLEAR, r_state != S_CLEAR, "clear sweep re-entered")
    `VRM_ASSERT_NEXT(a_result_wait, i_clk, i_rst_n, r_state == S_DONE && r_ovalid && !i_m_ready, r_state == S_DONE && r_ovalid, "result overwrote a pending transfer")
    `VRM_ASSERT_IMPL(a_div_in_wait, i_clk, i_rst_n, i_sts.div_done, r_state == S_DIVW, "divider finished outside its wait state")
endmodule

@@ test/voxel_ray_march_tb.sv @@
// self-checking testbench of the voxel ray marcher with a local predictor
`timescale 1ns / 1ps
module voxel_ray_march_tb;
    import vrm_pkg::*;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int GZ = 16;
    localparam int STEP_LIMIT = 512;
    localparam int DEPTH = GX * GY * GZ;
    localparam bit ACT_WRITE = 1'b0;
    localparam bit ACT_CAST  = 1'b1;

    typedef struct {
        logic         act;
        logic [127:0] data;
    } t_item;

    typedef struct {
        t_kind      kind;
        logic [7:0] code;
    } t_hit;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [127:0] s_data = '0;
    logic         s_user = 1'b0;
    logic         m_ready = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;
    logic         hold_arm = 1'b0;
    int           hold_cnt = 0;
    wire          s_ready;
    wire          m_valid;
    wire [7:0]    m_data;
    wire [1:0]    m_user;

    t_item  pending_items[$];
    t_hit   expected_hits[$];
    t_item  next_item;
    t_hit   got_hit;
    logic [7:0] voxel_mem[DEPTH];
    int     cur_eps, cur_border, cur_cap, cur_empty, cur_edge;
    int     send_idle = 0;
    int     recv_stall = 0;
    int     errors = 0;

    voxel_ray_march i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("ERROR t=%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic t_hit march_ray(input longint org[3], input longint dir[3]);
        longint p[3];
        longint lim[3];
        longint dead, t, s, f, num, ta, prod, mag, code;
        int near;
        t_hit r;
        lim[0] = GX * 1024;
        lim[1] = GY * 1024;
        lim[2] = GZ * 1024;
        dead = cur_eps * 16;
        p = org;
        for (int step = 0; step < STEP_LIMIT; step++) begin
            for (int a = 0; a < 3; a++) begin
                if (p[a] < 0 || p[a] >= lim[a]) begin
                    r.kind = KIND_ESCAPE;
                    r.code = cur_empty[7:0];
                    return r;
                end
            end
            code = voxel_mem[((p[2] >> 10) * GY + (p[1] >> 10)) * GX + (p[0] >> 10)];
            if (code != cur_empty) begin
                near = 0;
                for (int a = 0; a < 3; a++) begin
                    f = p[a] & 1023;
                    if (((f < 1024 - f) ? f : 1024 - f) < cur_border)
                        near++;
                end
                if (near >= 2) begin
                    r.kind = KIND_EDGE;
                    r.code = cur_edge[7:0];
                end else begin
                    r.kind = KIND_FACE;
                    r.code = code[7:0];
                end
                return r;
            end
            t = cur_cap;
            for (int a = 0; a < 3; a++) begin
                f = p[a] & 1023;
                if (dir[a] > dead)
                    num = 1024 - f;
                else if (dir[a] < -dead)
                    num = f;
                else
                    continue;
                ta = (num * 16384) / ((dir[a] < 0) ? -dir[a] : dir[a]);
                if (ta < t)
                    t = ta;
            end
            s = t + cur_eps;
            for (int a = 0; a < 3; a++) begin
                prod = s * dir[a];
                mag = (((prod < 0) ? -prod : prod) + 8192) / 16384;
                p[a] += (prod < 0) ? -mag : mag;
            end
        end
        r.kind = KIND_LIMIT;
        r.code = cur_empty[7:0];
        return r;
    endfunction

    task automatic take_transfer(input logic act, input logic [127:0] d);
        longint org[3];
        longint dir[3];
        if (act == ACT_WRITE) begin
            voxel_mem[(d[13:10] * GY + d[9:5]) * GX + d[4:0]] = d[21:14];
        end else begin
            org[0] = longint'($signed(d[38:22]));
            org[1] = longint'($signed(d[55:39]));
            org[2] = longint'($signed(d[72:56]));
            dir[0] = longint'($signed(d[88:73]));
            dir[1] = longint'($signed(d[104:89]));
            dir[2] = longint'($signed(d[120:105]));
            expected_hits.push_back(march_ray(org, dir));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                next_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_data <= next_item.data;
                s_user <= next_item.act;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver with optional long hold-off
    always @(posedge i_clk) begin
        if (hold_arm)
            hold_cnt <= 3000;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready)
                take_transfer(s_user, s_data);
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    report($sformatf("unexpected result kind %0d code %0d", m_user, m_data));
                end else begin
                    got_hit = expected_hits.pop_front();
                    if (m_user !== got_hit.kind)
                        report($sformatf("hit_kind %0d, expected %0d", m_user, got_hit.kind));
                    if (m_data !== got_hit.code)
                        report($sformatf("hit_code %0d, expected %0d", m_data, got_hit.code));
                end
            end
        end
    end

    function automatic void push_write(input int x, input int y, input int z, input int code);
        t_item it;
        it.act = ACT_WRITE;
        it.data = {$urandom, $urandom, $urandom, $urandom};
        it.data[4:0] = 5'(x);
        it.data[9:5] = 5'(y);
        it.data[13:10] = 4'(z);
        it.data[21:14] = 8'(code);
        it.data[127:121] = '0;
        pending_items.push_back(it);
    endfunction

    function automatic void push_cast(input int ox, input int oy, input int oz,
                                      input int dx, input int dy, input int dz);
        t_item it;
        it.act = ACT_CAST;
        it.data = {$urandom, $urandom, $urandom, $urandom};
        it.data[38:22] = 17'(ox);
        it.data[55:39] = 17'(oy);
        it.data[72:56] = 17'(oz);
        it.data[88:73] = 16'(dx);
        it.data[104:89] = 16'(dy);
        it.data[120:105] = 16'(dz);
        it.data[127:121] = '0;
        pending_items.push_back(it);
    endfunction

    function automatic int rand_dir();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic void push_random(input int n, input int cast_pct);
        int ox, oy, oz;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) >= cast_pct) begin
                if ($urandom_range(9) < 7)
                    push_write($urandom_range(8, 15), $urandom_range(8, 15),
                               $urandom_range(4, 9), $urandom_range(255));
                else
                    push_write($urandom_range(31), $urandom_range(31),
                               $urandom_range(15), $urandom_range(255));
            end else if ($urandom_range(9) < 8) begin
                ox = $urandom_range(4 * 1024, 20 * 1024);
                oy = $urandom_range(4 * 1024, 20 * 1024);
                oz = $urandom_range(2 * 1024, 12 * 1024);
                if ($urandom_range(3) == 0) begin
                    ox = ox & ~1023;
                    oy = oy & ~1023;
                end
                push_cast(ox, oy, oz, rand_dir(), rand_dir(), rand_dir());
            end else begin
                push_cast($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_regs(input int eps, input int border, input int cap,
                            input int empty, input int edge_val);
        int vals[5];
        vals = '{eps, border, cap, empty, edge_val};
        for (int r = 0; r < 5; r++) begin
            @(posedge i_clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IW'(r);
            cfg_data <= CFG_DW'(vals[r]);
        end
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_eps = eps & 1023;
        cur_border = border & 511;
        cur_cap = cap & 65535;
        cur_empty = empty & 255;
        cur_edge = edge_val & 255;
    endtask

    initial begin
        foreach (voxel_mem[i])
            voxel_mem[i] = RESET_CODE;
        cur_eps = EPS_RST;
        cur_border = BORDER_RST;
        cur_cap = CAP_RST;
        cur_empty = EMPTY_RST;
        cur_edge = EDGE_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset settings
        push_write(0, 0, 0, 0);
        push_write(31, 31, 15, 255);
        push_write(5, 5, 5, 77);
        push_write(9, 5, 5, 200);
        push_cast(5 * 1024 + 512, 5 * 1024 + 512, 5 * 1024 + 512, 0, 16384, 0);
        push_cast(5 * 1024, 5 * 1024, 5 * 1024 + 512, 16384, 0, 0);
        push_cast(2 * 1024 + 512, 5 * 1024 + 512, 5 * 1024 + 512, 16384, 0, 0);
        push_cast(20 * 1024 + 512, 5 * 1024 + 512, 5 * 1024 + 512, -16384, 0, 0);
        push_cast(512, 512, 512, 0, 0, 0);
        push_cast(1536, 1536, 1536, 100, -100, 50);
        push_cast(-65536, 512, 512, 16384, 0, 0);
        push_cast(65535, 65535, 65535, -16384, -16384, -16384);
        push_cast(31 * 1024 + 512, 31 * 1024 + 512, 15 * 1024 + 512, 0, 0, 16384);
        push_cast(512, 512, 512, -32768, 32767, 0);
        push_cast(3 * 1024, 7 * 1024, 1024, 11585, 11585, 0);
        push_cast(6 * 1024 + 300, 5 * 1024 + 700, 5 * 1024 + 20, 9459, 9459, 9459);
        push_write(5, 5, 5, 32);
        push_cast(5 * 1024 + 512, 5 * 1024 + 512, 5 * 1024 + 512, 16384, 0, 0);
        push_cast(0, 0, 0, 16384, 16384, 16384);
        push_cast(32 * 1024 - 1, 32 * 1024 - 1, 16 * 1024 - 1, 1, 1, 1);
        wait_drained();

        set_regs(5, 100, 3000, 32, 7);
        send_idle = 56;
        push_random(300, 40);
        wait_drained();

        set_regs(0, 0, 1, 0, 255);
        send_idle = 0;
        recv_stall = 56;
        push_random(20, 10);
        wait_drained();

        set_regs(1023, 511, 65535, 255, 0);
        send_idle = 22;
        recv_stall = 22;
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        push_random(200, 40);
        wait_drained();

        set_regs(300, 20, 0, 32, 45);
        send_idle = 0;
        recv_stall = 0;
        push_random(30, 30);
        wait_drained();

        set_regs($urandom_range(60), $urandom_range(511), $urandom_range(256, 4096),
                 $urandom_range(255), $urandom_range(255));
        recv_stall = 56;
        push_random(600, 40);
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #600000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
